### hdl/psl_pkg.sv
package psl_pkg;

  // offset counter width inside the block; outputs carry the low 16 bits
  localparam int POS_BITS   = 16;
  localparam int LINE_BITS  = 16;
  localparam int FIELD_BITS = 16;
  localparam int CHAR_BITS  = 8;
  localparam int KIND_BITS  = 5;

  // token and error kinds
  typedef enum logic [KIND_BITS-1:0] {
    K_LPAREN   = 5'd0,
    K_RPAREN   = 5'd1,
    K_LBRACE   = 5'd2,
    K_RBRACE   = 5'd3,
    K_COMMA    = 5'd4,
    K_DOT      = 5'd5,
    K_MINUS    = 5'd6,
    K_PLUS     = 5'd7,
    K_SEMI     = 5'd8,
    K_STAR     = 5'd9,
    K_BANG     = 5'd10,
    K_BANG_EQ  = 5'd11,
    K_EQ       = 5'd12,
    K_EQ_EQ    = 5'd13,
    K_LT       = 5'd14,
    K_LE       = 5'd15,
    K_GT       = 5'd16,
    K_GE       = 5'd17,
    K_SLASH    = 5'd18,
    K_STRING   = 5'd19,
    K_EOF      = 5'd20,
    K_BAD      = 5'd21,
    K_UNTERM   = 5'd22
  } kind_t;

  // source characters of interest
  localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_NL     = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_BANG   = 8'h21;
  localparam logic [CHAR_BITS-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_BITS-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_BITS-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_BITS-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_BITS-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_BITS-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_BITS-1:0] CH_LT     = 8'h3C;
  localparam logic [CHAR_BITS-1:0] CH_EQ     = 8'h3D;
  localparam logic [CHAR_BITS-1:0] CH_GT     = 8'h3E;
  localparam logic [CHAR_BITS-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_BITS-1:0] CH_RBRACE = 8'h7D;

  // one result as queued for output
  typedef struct packed {
    kind_t                  kind;
    logic [LINE_BITS-1:0]   line_no;
    logic [FIELD_BITS-1:0]  start_pos;
    logic [FIELD_BITS-1:0]  token_len;
    logic [CHAR_BITS-1:0]   bad_char;
    logic                   last;
  } res_t;

  // offset to output field width, zero extended or truncated
  function automatic logic [FIELD_BITS-1:0] to_field(input logic [POS_BITS-1:0] v);
    logic [POS_BITS+FIELD_BITS-1:0] w;
    w = {{FIELD_BITS{1'b0}}, v};
    return w[FIELD_BITS-1:0];
  endfunction

endpackage

### hdl/punctuation_string_lexer.sv
// Byte-serial scanner for punctuators, one- and two-character operators, // comments and
// strings. One source byte is taken per cycle on the s_axis side while there is queue room (a
// zero byte ends the text and returns the block to offset 0, line 1); tokens leave on the m_axis
// side one per cycle while m_axis_tready is high, out of the result queue, with tlast on the last
// token a byte causes. A byte causes at most two tokens and results wait in a four-entry queue,
// so the input keeps running at one byte per cycle while every byte yields at most one token
// and the output is ready; text in which bytes yield two tokens each is held back by the single
// output port. Offsets and the line count saturate at their maximum.
module punctuation_string_lexer
  import psl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [CHAR_BITS-1:0]    s_axis_tdata,   // ch
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [55:0]             m_axis_tdata,   // line_no, start_pos, token_len, bad_char
  output logic [KIND_BITS-1:0]    m_axis_tuser,   // result_kind
  output logic                    m_axis_tlast    // last
);

  typedef enum logic [2:0] {
    M_IDLE, M_BANG, M_EQ, M_LT, M_GT, M_SLASH, M_COMMENT, M_STRING
  } mode_t;

  localparam int DEPTH     = 4;
  localparam int PTR_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam logic [POS_BITS-1:0]  POS_MAX  = {POS_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  mode_t                 mode, mode_next;
  logic [LINE_BITS-1:0]  line_count, line_next;
  logic [POS_BITS-1:0]   position, position_next;
  logic [POS_BITS-1:0]   token_start, token_start_next;

  res_t                  queue [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr, rd_ptr, wr_ptr_next, wr_slot2;
  logic [CNT_BITS-1:0]   count, count_next;

  logic                  in_fire, out_fire, line_inc;
  logic [1:0]            n_res;
  res_t                  r0, r1, pend_res, idle_res;
  logic                  idle_emit, idle_set_ts, idle_nl;
  mode_t                 idle_mode;
  logic [CHAR_BITS-1:0]  ch;
  kind_t                 pend_kind;
  logic                  ch_is_eq;

  assign ch       = s_axis_tdata;
  assign ch_is_eq = (ch == CH_EQ);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // room for two results whatever the output does
  assign s_axis_tready = (count <= CNT_BITS'(DEPTH - 2));

  // byte taken with no pending token
  always_comb begin
    idle_emit   = 1'b1;
    idle_set_ts = 1'b0;
    idle_nl     = 1'b0;
    idle_mode   = M_IDLE;
    idle_res    = '{kind: K_BAD, line_no: line_count, start_pos: to_field(position),
                    token_len: FIELD_BITS'(1), bad_char: '0, last: 1'b0};
    case (ch)
      CH_LPAREN: idle_res.kind = K_LPAREN;
      CH_RPAREN: idle_res.kind = K_RPAREN;
      CH_LBRACE: idle_res.kind = K_LBRACE;
      CH_RBRACE: idle_res.kind = K_RBRACE;
      CH_COMMA:  idle_res.kind = K_COMMA;
      CH_DOT:    idle_res.kind = K_DOT;
      CH_MINUS:  idle_res.kind = K_MINUS;
      CH_PLUS:   idle_res.kind = K_PLUS;
      CH_SEMI:   idle_res.kind = K_SEMI;
      CH_STAR:   idle_res.kind = K_STAR;
      CH_NUL: begin
        idle_res.kind      = K_EOF;
        idle_res.token_len = '0;
      end
      CH_BANG: begin
        idle_emit = 1'b0; idle_set_ts = 1'b1; idle_mode = M_BANG;
      end
      CH_EQ: begin
        idle_emit = 1'b0; idle_set_ts = 1'b1; idle_mode = M_EQ;
      end
      CH_LT: begin
        idle_emit = 1'b0; idle_set_ts = 1'b1; idle_mode = M_LT;
      end
      CH_GT: begin
        idle_emit = 1'b0; idle_set_ts = 1'b1; idle_mode = M_GT;
      end
      CH_SLASH: begin
        idle_emit = 1'b0; idle_set_ts = 1'b1; idle_mode = M_SLASH;
      end
      CH_QUOTE: begin
        idle_emit = 1'b0; idle_set_ts = 1'b1; idle_mode = M_STRING;
      end
      CH_NL: begin
        idle_emit = 1'b0; idle_nl = 1'b1;
      end
      CH_CR, CH_TAB, CH_SPACE: idle_emit = 1'b0;
      default: idle_res.bad_char = ch;
    endcase
  end

  // kind of the pending operator, decided by this byte
  always_comb begin
    case (mode)
      M_BANG:  pend_kind = ch_is_eq ? K_BANG_EQ : K_BANG;
      M_EQ:    pend_kind = ch_is_eq ? K_EQ_EQ : K_EQ;
      M_LT:    pend_kind = ch_is_eq ? K_LE : K_LT;
      M_GT:    pend_kind = ch_is_eq ? K_GE : K_GT;
      default: pend_kind = K_SLASH;
    endcase
    pend_res = '{kind: pend_kind, line_no: line_count, start_pos: to_field(token_start),
                 token_len: (ch_is_eq && mode != M_SLASH) ? FIELD_BITS'(2) : FIELD_BITS'(1),
                 bad_char: '0, last: 1'b0};
  end

  // per-byte mode update and results
  always_comb begin
    n_res            = 2'd0;
    r0               = idle_res;
    r1               = idle_res;
    mode_next        = mode;
    token_start_next = token_start;
    line_inc         = 1'b0;
    case (mode)
      M_BANG, M_EQ, M_LT, M_GT, M_SLASH: begin
        r0 = pend_res;
        if (mode == M_SLASH && ch == CH_SLASH) begin
          r0        = idle_res;
          mode_next = M_COMMENT;
        end else if (mode != M_SLASH && ch_is_eq) begin
          n_res     = 2'd1;
          mode_next = M_IDLE;
        end else begin
          n_res     = idle_emit ? 2'd2 : 2'd1;
          mode_next = idle_mode;
          line_inc  = idle_nl;
          if (idle_set_ts) token_start_next = position;
        end
      end
      M_COMMENT: begin
        if (ch == CH_NL) begin
          line_inc  = 1'b1;
          mode_next = M_IDLE;
        end else if (ch == CH_NUL) begin
          n_res = 2'd1;
        end
      end
      M_STRING: begin
        if (ch == CH_QUOTE) begin
          n_res        = 2'd1;
          mode_next    = M_IDLE;
          r0.kind      = K_STRING;
          r0.start_pos = to_field(token_start + POS_BITS'(1));
          r0.token_len = (position > token_start) ?
                         to_field(position - token_start - POS_BITS'(1)) : '0;
          r0.bad_char  = '0;
        end else if (ch == CH_NL) begin
          line_inc = 1'b1;
        end else if (ch == CH_NUL) begin
          n_res        = 2'd2;
          r0.kind      = K_UNTERM;
          r0.start_pos = to_field(token_start);
          r0.token_len = (position >= token_start) ? to_field(position - token_start) : '0;
          r0.bad_char  = '0;
        end
      end
      default: begin
        n_res     = idle_emit ? 2'd1 : 2'd0;
        mode_next = idle_mode;
        line_inc  = idle_nl;
        if (idle_set_ts) token_start_next = position;
      end
    endcase
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;

    // end of text returns to the start of a fresh text
    if (ch == CH_NUL) begin
      mode_next        = M_IDLE;
      line_next        = LINE_BITS'(1);
      position_next    = '0;
      token_start_next = '0;
    end else begin
      line_next     = (line_inc && line_count != LINE_MAX) ?
                      line_count + LINE_BITS'(1) : line_count;
      position_next = (position != POS_MAX) ? position + POS_BITS'(1) : position;
    end
  end

  // queue pointers
  assign wr_slot2    = wr_ptr + PTR_BITS'(1);
  assign wr_ptr_next = in_fire ? wr_ptr + PTR_BITS'(n_res) : wr_ptr;
  assign count_next  = count + (in_fire ? CNT_BITS'(n_res) : '0) - CNT_BITS'(out_fire);

  // scanner state and result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      line_count  <= LINE_BITS'(1);
      position    <= '0;
      token_start <= '0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
    end else begin
      if (in_fire) begin
        mode        <= mode_next;
        line_count  <= line_next;
        position    <= position_next;
        token_start <= token_start_next;
      end
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (out_fire) rd_ptr <= rd_ptr + PTR_BITS'(1);
    end
    if (in_fire && n_res != 2'd0) queue[wr_ptr] <= r0;
    if (in_fire && n_res == 2'd2) queue[wr_slot2] <= r1;
  end

  // output side
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tuser  = queue[rd_ptr].kind;
  assign m_axis_tlast  = queue[rd_ptr].last;
  assign m_axis_tdata  = {queue[rd_ptr].bad_char, queue[rd_ptr].token_len,
                          queue[rd_ptr].start_pos, queue[rd_ptr].line_no};

`ifndef NO_ASSERTIONS
  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(DEPTH))
    else $error("result queue overflow");

  // end of text always produces a token next cycle
  a_eof_out: assert property (@(posedge clk) disable iff (rst)
    in_fire && ch == CH_NUL |=> m_axis_tvalid)
    else $error("no token after end of text");

  // end of text restarts offsets and lines
  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && ch == CH_NUL |=> position == '0 && line_count == LINE_BITS'(1)
                                && mode == M_IDLE)
    else $error("state not restarted after end of text");

  // line count never wraps to zero
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_count != '0)
    else $error("line count reached zero");
`endif

endmodule
